>>> hw/rtl/lik_pkg.sv
`timescale 1ns / 1ps

package lik_pkg;

    localparam int CORD_W = 36;
    localparam int ACC_W = 32;
    localparam int ATAN_TAB_LEN = 24;
    localparam int NUM_W = 50;
    localparam int DEN_W = 46;
    localparam int QUO_W = 17;

    localparam logic [1:0] CFG_COXA = 2'd0;
    localparam logic [1:0] CFG_FEMUR = 2'd1;
    localparam logic [1:0] CFG_TIBIA = 2'd2;
    localparam logic [1:0] CFG_HIP_OFFSET = 2'd3;

    localparam logic [11:0] COXA_RESET = 12'd30;
    localparam logic [11:0] FEMUR_RESET = 12'd60;
    localparam logic [11:0] TIBIA_RESET = 12'd90;
    localparam logic signed [8:0] HIP_OFFSET_RESET = 9'sd45;

    localparam logic signed [ACC_W-1:0] DEG90_Q16 = 32'sd5898240;
    localparam logic [7:0] SERVO_MAX = 8'd180;

    typedef struct packed {
        logic [11:0] coxa_length;
        logic [11:0] femur_length;
        logic [11:0] tibia_length;
        logic signed [8:0] hip_offset_deg;
    } lik_cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START1,
        ST_WAIT1,
        ST_DIST,
        ST_DSQ,
        ST_START2,
        ST_WAIT2,
        ST_FF,
        ST_TT,
        ST_FL,
        ST_NUM1,
        ST_CHK,
        ST_DIV,
        ST_CSQ,
        ST_SIN,
        ST_SINW,
        ST_ACW,
        ST_TF,
        ST_NUM2,
        ST_OUT
    } lik_state_t;

    typedef enum logic [1:0] {
        SQ_L1,
        SQ_LSQ,
        SQ_SIN
    } lik_sq_src_t;

    typedef enum logic [1:0] {
        CD_HIP,
        CD_A1,
        CD_ACOS
    } lik_cd_src_t;

    typedef struct packed {
        logic q_pop;
        logic sq_start;
        lik_sq_src_t sq_src;
        logic cd_start;
        lik_cd_src_t cd_src;
        logic out_load;
    } lik_ctrl_t;

    function automatic logic [21:0] lik_atan(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0: v = 22'd2949120;
            5'd1: v = 22'd1740967;
            5'd2: v = 22'd919879;
            5'd3: v = 22'd466945;
            5'd4: v = 22'd234379;
            5'd5: v = 22'd117304;
            5'd6: v = 22'd58666;
            5'd7: v = 22'd29335;
            5'd8: v = 22'd14668;
            5'd9: v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/lik_target_if.sv
`timescale 1ns / 1ps

interface lik_target_if #(
    parameter int COORD_BITS = 13
) ();
    logic valid;
    logic ready;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic signed [COORD_BITS-1:0] target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink (input valid, input target_x, input target_y, input target_z,
                  output ready);
endinterface

>>> hw/rtl/lik_angle_if.sv
`timescale 1ns / 1ps

interface lik_angle_if ();
    logic valid;
    logic ready;
    logic [7:0] hip_angle;
    logic [7:0] shoulder_angle;
    logic [7:0] knee_angle;
    logic unreachable;

    modport source (output valid, output hip_angle, output shoulder_angle,
                    output knee_angle, output unreachable, input ready);
    modport sink (input valid, input hip_angle, input shoulder_angle,
                  input knee_angle, input unreachable, output ready);
endinterface

>>> hw/rtl/lik_front.sv
`timescale 1ns / 1ps

module lik_front #(
    parameter int COORD_BITS = 13,
    parameter int DATA_W = 7 * COORD_BITS - 1
) (
    input  logic              clk,
    input  logic              rst_n,
    lik_target_if.sink        target,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [DATA_W-1:0] push_data
);
    localparam int CB = COORD_BITS;

    logic fv_reg;
    logic signed [CB-1:0] x_reg;
    logic signed [CB-1:0] y_reg;
    logic signed [CB-1:0] z_reg;
    logic [2*CB-1:0] rxy_reg;
    logic [2*CB-2:0] zz_reg;
    logic signed [2*CB-1:0] xx;
    logic signed [2*CB-1:0] yy;
    logic signed [2*CB-1:0] zsq;
    logic accept;

    assign target.ready = !fv_reg || push_ready;
    assign accept = target.valid && target.ready;
    assign xx = target.target_x * target.target_x;
    assign yy = target.target_y * target.target_y;
    assign zsq = target.target_z * target.target_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (accept)
        begin
            fv_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= target.target_x;
            y_reg <= target.target_y;
            z_reg <= target.target_z;
            rxy_reg <= $unsigned(xx) + $unsigned(yy);
            zz_reg <= zsq[2*CB-2:0];
        end
    end

    assign push_valid = fv_reg;
    assign push_data = {x_reg, y_reg, z_reg, rxy_reg, zz_reg};
endmodule

>>> hw/rtl/lik_queue.sv
`timescale 1ns / 1ps

module lik_queue #(
    parameter int DATA_W = 90
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data
);
    logic [DATA_W-1:0] mem_reg [2];
    logic wp_reg;
    logic rp_reg;
    logic [1:0] cnt_reg;
    logic do_push;
    logic do_pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid = cnt_reg != 2'd0;
    assign do_push = push_valid && push_ready;
    assign do_pop = pop && pop_valid;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end
endmodule

>>> hw/rtl/lik_back.sv
`timescale 1ns / 1ps

module lik_back #(
    parameter int COORD_BITS = 13,
    parameter int CORDIC_STEPS = 16,
    parameter int DATA_W = 7 * COORD_BITS - 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lik_pkg::lik_cfg_t cfg,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [DATA_W-1:0] q_data,
    lik_angle_if.source       angles
);
    localparam int CB = COORD_BITS;
    localparam int CW = lik_pkg::CORD_W;
    localparam int AW = lik_pkg::ACC_W;
    localparam int NW = lik_pkg::NUM_W;
    localparam int DW = lik_pkg::DEN_W;
    localparam int QW = lik_pkg::QUO_W;
    localparam int NSTEPS = (CORDIC_STEPS < lik_pkg::ATAN_TAB_LEN) ?
                            CORDIC_STEPS : lik_pkg::ATAN_TAB_LEN;
    localparam int OFF_ZZ = 0;
    localparam int OFF_RXY = 2 * CB - 1;
    localparam int OFF_Z = OFF_RXY + 2 * CB;
    localparam int OFF_Y = OFF_Z + CB;
    localparam int OFF_X = OFF_Y + CB;

    lik_pkg::lik_state_t state_reg, state_next;
    lik_pkg::lik_ctrl_t ctl;

    logic signed [CB-1:0] x_reg, y_reg, z_reg;
    logic [2*CB-1:0] rxy_reg;
    logic [2*CB-2:0] zz_reg;
    logic [31:0] dm_reg;
    logic [31:0] lq_reg;
    logic [63:0] lsq_reg;
    logic [63:0] prod_reg;
    logic [23:0] ff_reg, tt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic neg_reg;
    logic knee_sel_reg;
    logic ok_reg;
    logic signed [AW-1:0] a1_reg;
    logic [7:0] hip_reg, sh_reg, kn_reg;

    logic sq_run_reg;
    logic [4:0] sq_cnt_reg;
    logic [63:0] sq_v_reg, sq_r_reg;
    logic cd_run_reg;
    logic [4:0] cd_cnt_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [AW-1:0] acc_reg;
    logic cz_reg;
    logic [3:0] div_cnt_reg;

    logic ov_reg;
    logic [7:0] o_hip_reg, o_sh_reg, o_kn_reg;
    logic o_unr_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] sq_bit, sq_try, sq_v_next, sq_r_next, sq_v0, lsq_sum;
    logic [4:0] sq_cnt0;
    logic [5:0] sq_sh;
    logic [32:0] sin_arg;
    logic signed [CW-1:0] ix, iy, x0, y0, cdx, cdy;
    logic signed [AW-1:0] a0, cres, tab;
    logic signed [33:0] reach_d;
    logic [NW-1:0] mag;
    logic [DW:0] rem2;
    logic signed [17:0] cval;
    logic [24:0] fdiff, fsum;
    logic [11:0] f_len, t_len;
    logic sq_done, cd_done, chk_fail;
    logic div_last;

    function automatic logic [7:0] to_servo(input logic signed [AW-1:0] q);
        logic [7:0] r;
        if (q[AW-1])
        begin
            r = 8'd0;
        end
        else if (q[AW-1:16] > 16'(lik_pkg::SERVO_MAX))
        begin
            r = lik_pkg::SERVO_MAX;
        end
        else
        begin
            r = q[23:16];
        end
        return r;
    endfunction

    assign f_len = cfg.femur_length;
    assign t_len = cfg.tibia_length;
    assign sq_done = sq_cnt_reg == 5'd31;
    assign cd_done = cd_cnt_reg == 5'(NSTEPS - 1);
    assign cres = cz_reg ? '0 : acc_reg;
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    // square root, one result bit per cycle
    assign sq_sh = 6'd62 - {sq_cnt_reg, 1'b0};
    assign sq_bit = 64'd1 << sq_sh;
    assign sq_try = sq_r_reg + sq_bit;
    always_comb
    begin
        if (sq_v_reg >= sq_try)
        begin
            sq_v_next = sq_v_reg - sq_try;
            sq_r_next = (sq_r_reg >> 1) + sq_bit;
        end
        else
        begin
            sq_v_next = sq_v_reg;
            sq_r_next = sq_r_reg >> 1;
        end
    end

    assign lsq_sum = 64'({zz_reg, 32'b0}) + prod_reg;
    assign sin_arg = 33'h1_0000_0000 - prod_reg[32:0];

    always_comb
    begin
        unique case (ctl.sq_src)
            lik_pkg::SQ_L1:
            begin
                sq_v0 = 64'({rxy_reg, 32'b0});
                sq_cnt0 = 5'd0;
            end
            lik_pkg::SQ_LSQ:
            begin
                sq_v0 = lsq_sum;
                sq_cnt0 = 5'd0;
            end
            default:
            begin
                sq_v0 = 64'(sin_arg);
                sq_cnt0 = 5'd15;
            end
        endcase
    end

    // vectoring source and quadrant pre-rotation
    assign cval = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    always_comb
    begin
        unique case (ctl.cd_src)
            lik_pkg::CD_HIP:
            begin
                iy = {{(CW-CB-16){x_reg[CB-1]}}, x_reg, 16'b0};
                ix = {{(CW-CB-16){y_reg[CB-1]}}, y_reg, 16'b0};
            end
            lik_pkg::CD_A1:
            begin
                iy = {{(CW-32){1'b0}}, dm_reg};
                ix = {{(CW-CB-16){z_reg[CB-1]}}, z_reg, 16'b0};
            end
            default:
            begin
                iy = {{(CW-29){1'b0}}, sq_r_reg[16:0], 12'b0};
                ix = {{(CW-30){cval[17]}}, cval, 12'b0};
            end
        endcase
        if (ix[CW-1])
        begin
            if (!iy[CW-1])
            begin
                x0 = iy;
                y0 = -ix;
                a0 = lik_pkg::DEG90_Q16;
            end
            else
            begin
                x0 = -iy;
                y0 = ix;
                a0 = -lik_pkg::DEG90_Q16;
            end
        end
        else
        begin
            x0 = ix;
            y0 = iy;
            a0 = '0;
        end
    end

    assign cdx = cy_reg >>> cd_cnt_reg;
    assign cdy = cx_reg >>> cd_cnt_reg;
    assign tab = AW'(lik_pkg::lik_atan(cd_cnt_reg));

    assign reach_d = $signed({2'b0, sq_r_reg[31:0]}) -
                     $signed({6'b0, cfg.coxa_length, 16'b0});
    assign mag = num_reg[NW-1] ? -num_reg : num_reg;
    assign chk_fail = (den_reg == '0) || (mag > NW'(den_reg));
    assign rem2 = {rem_reg, 1'b0};
    assign fdiff = {1'b0, ff_reg} - {1'b0, tt_reg};
    assign fsum = {1'b0, ff_reg} + {1'b0, tt_reg};

    always_comb
    begin
        unique case (state_reg)
            lik_pkg::ST_DSQ:
            begin
                mul_a = dm_reg;
                mul_b = dm_reg;
            end
            lik_pkg::ST_FF:
            begin
                mul_a = 32'(f_len);
                mul_b = 32'(f_len);
            end
            lik_pkg::ST_TT:
            begin
                mul_a = 32'(t_len);
                mul_b = 32'(t_len);
            end
            lik_pkg::ST_FL:
            begin
                mul_a = 32'(f_len);
                mul_b = lq_reg;
            end
            lik_pkg::ST_CSQ:
            begin
                mul_a = 32'(quo_reg);
                mul_b = 32'(quo_reg);
            end
            lik_pkg::ST_TF:
            begin
                mul_a = 32'(t_len);
                mul_b = 32'(f_len);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_last = div_cnt_reg == 4'd15;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lik_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = lik_pkg::ST_START1;
                end
            end
            lik_pkg::ST_START1: state_next = lik_pkg::ST_WAIT1;
            lik_pkg::ST_WAIT1:
            begin
                if (!sq_run_reg && !cd_run_reg)
                begin
                    state_next = lik_pkg::ST_DIST;
                end
            end
            lik_pkg::ST_DIST: state_next = lik_pkg::ST_DSQ;
            lik_pkg::ST_DSQ: state_next = lik_pkg::ST_START2;
            lik_pkg::ST_START2: state_next = lik_pkg::ST_WAIT2;
            lik_pkg::ST_WAIT2:
            begin
                if (!sq_run_reg && !cd_run_reg)
                begin
                    state_next = (lsq_reg == '0) ? lik_pkg::ST_OUT : lik_pkg::ST_FF;
                end
            end
            lik_pkg::ST_FF: state_next = lik_pkg::ST_TT;
            lik_pkg::ST_TT: state_next = lik_pkg::ST_FL;
            lik_pkg::ST_FL: state_next = lik_pkg::ST_NUM1;
            lik_pkg::ST_NUM1: state_next = lik_pkg::ST_CHK;
            lik_pkg::ST_CHK: state_next = chk_fail ? lik_pkg::ST_OUT : lik_pkg::ST_DIV;
            lik_pkg::ST_DIV: state_next = div_last ? lik_pkg::ST_CSQ : lik_pkg::ST_DIV;
            lik_pkg::ST_CSQ: state_next = lik_pkg::ST_SIN;
            lik_pkg::ST_SIN: state_next = lik_pkg::ST_SINW;
            lik_pkg::ST_SINW:
            begin
                if (!sq_run_reg)
                begin
                    state_next = lik_pkg::ST_ACW;
                end
            end
            lik_pkg::ST_ACW:
            begin
                if (!cd_run_reg)
                begin
                    state_next = knee_sel_reg ? lik_pkg::ST_OUT : lik_pkg::ST_TF;
                end
            end
            lik_pkg::ST_TF: state_next = lik_pkg::ST_NUM2;
            lik_pkg::ST_NUM2: state_next = lik_pkg::ST_CHK;
            lik_pkg::ST_OUT:
            begin
                if (!ov_reg || angles.ready)
                begin
                    state_next = lik_pkg::ST_IDLE;
                end
            end
            default: state_next = lik_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.sq_src = lik_pkg::SQ_L1;
        ctl.cd_src = lik_pkg::CD_HIP;
        unique case (state_reg)
            lik_pkg::ST_IDLE: ctl.q_pop = q_valid;
            lik_pkg::ST_START1:
            begin
                ctl.sq_start = 1'b1;
                ctl.cd_start = 1'b1;
            end
            lik_pkg::ST_START2:
            begin
                ctl.sq_start = 1'b1;
                ctl.sq_src = lik_pkg::SQ_LSQ;
                ctl.cd_start = 1'b1;
                ctl.cd_src = lik_pkg::CD_A1;
            end
            lik_pkg::ST_SIN:
            begin
                ctl.sq_start = 1'b1;
                ctl.sq_src = lik_pkg::SQ_SIN;
            end
            lik_pkg::ST_SINW:
            begin
                ctl.cd_start = !sq_run_reg;
                ctl.cd_src = lik_pkg::CD_ACOS;
            end
            lik_pkg::ST_OUT: ctl.out_load = !ov_reg || angles.ready;
            default: ctl = ctl;
        endcase
    end

    assign q_pop = ctl.q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lik_pkg::ST_IDLE;
            sq_run_reg <= 1'b0;
            sq_cnt_reg <= 5'd0;
            cd_run_reg <= 1'b0;
            cd_cnt_reg <= 5'd0;
            div_cnt_reg <= 4'd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.sq_start)
            begin
                sq_run_reg <= 1'b1;
                sq_cnt_reg <= sq_cnt0;
            end
            else if (sq_run_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
                if (sq_done)
                begin
                    sq_run_reg <= 1'b0;
                end
            end
            if (ctl.cd_start)
            begin
                cd_run_reg <= 1'b1;
                cd_cnt_reg <= 5'd0;
            end
            else if (cd_run_reg)
            begin
                cd_cnt_reg <= cd_cnt_reg + 5'd1;
                if (cd_done)
                begin
                    cd_run_reg <= 1'b0;
                end
            end
            if (state_reg == lik_pkg::ST_CHK)
            begin
                div_cnt_reg <= 4'd0;
            end
            else if (state_reg == lik_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            if (ctl.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (angles.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sq_start)
        begin
            sq_v_reg <= sq_v0;
            sq_r_reg <= '0;
        end
        else if (sq_run_reg)
        begin
            sq_v_reg <= sq_v_next;
            sq_r_reg <= sq_r_next;
        end

        if (ctl.cd_start)
        begin
            cx_reg <= x0;
            cy_reg <= y0;
            acc_reg <= a0;
            cz_reg <= (ix == '0) && (iy == '0);
        end
        else if (cd_run_reg)
        begin
            if (!cy_reg[CW-1])
            begin
                cx_reg <= cx_reg + cdx;
                cy_reg <= cy_reg - cdy;
                acc_reg <= acc_reg + tab;
            end
            else
            begin
                cx_reg <= cx_reg - cdx;
                cy_reg <= cy_reg + cdy;
                acc_reg <= acc_reg - tab;
            end
        end

        if (ctl.out_load)
        begin
            o_hip_reg <= hip_reg;
            o_sh_reg <= ok_reg ? sh_reg : 8'd0;
            o_kn_reg <= ok_reg ? kn_reg : 8'd0;
            o_unr_reg <= !ok_reg;
        end

        unique case (state_reg)
            lik_pkg::ST_IDLE:
            begin
                ok_reg <= 1'b1;
                x_reg <= q_data[OFF_X +: CB];
                y_reg <= q_data[OFF_Y +: CB];
                z_reg <= q_data[OFF_Z +: CB];
                rxy_reg <= q_data[OFF_RXY +: 2*CB];
                zz_reg <= q_data[OFF_ZZ +: 2*CB-1];
            end
            lik_pkg::ST_DIST:
            begin
                dm_reg <= reach_d[33] ? 32'(-reach_d) : reach_d[31:0];
                hip_reg <= to_servo(cres +
                           {{7{cfg.hip_offset_deg[8]}}, cfg.hip_offset_deg, 16'b0});
            end
            lik_pkg::ST_DSQ: prod_reg <= mul_p;
            lik_pkg::ST_START2: lsq_reg <= lsq_sum;
            lik_pkg::ST_WAIT2:
            begin
                if (!sq_run_reg && !cd_run_reg)
                begin
                    a1_reg <= cres;
                    lq_reg <= sq_r_reg[31:0];
                    if (lsq_reg == '0)
                    begin
                        ok_reg <= 1'b0;
                    end
                end
            end
            lik_pkg::ST_FF: prod_reg <= mul_p;
            lik_pkg::ST_TT:
            begin
                ff_reg <= prod_reg[23:0];
                prod_reg <= mul_p;
            end
            lik_pkg::ST_FL:
            begin
                tt_reg <= prod_reg[23:0];
                prod_reg <= mul_p;
            end
            lik_pkg::ST_NUM1:
            begin
                num_reg <= {2'b0, lsq_reg[63:16]} + {{9{fdiff[24]}}, fdiff, 16'b0};
                den_reg <= {prod_reg[44:0], 1'b0};
                knee_sel_reg <= 1'b0;
            end
            lik_pkg::ST_CHK:
            begin
                if (chk_fail)
                begin
                    ok_reg <= 1'b0;
                end
                neg_reg <= num_reg[NW-1];
                quo_reg <= QW'(mag == NW'(den_reg));
                rem_reg <= (mag == NW'(den_reg)) ? '0 : mag[DW-1:0];
            end
            lik_pkg::ST_DIV:
            begin
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_reg <= DW'(rem2 - {1'b0, den_reg});
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[DW-1:0];
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
            end
            lik_pkg::ST_CSQ: prod_reg <= mul_p;
            lik_pkg::ST_ACW:
            begin
                if (!cd_run_reg)
                begin
                    if (knee_sel_reg)
                    begin
                        kn_reg <= to_servo(cres);
                    end
                    else
                    begin
                        sh_reg <= to_servo(a1_reg + cres);
                    end
                end
            end
            lik_pkg::ST_TF: prod_reg <= mul_p;
            lik_pkg::ST_NUM2:
            begin
                num_reg <= {9'b0, fsum, 16'b0} - {2'b0, lsq_reg[63:16]};
                den_reg <= {5'b0, prod_reg[23:0], 17'b0};
                knee_sel_reg <= 1'b1;
            end
            default: prod_reg <= prod_reg;
        endcase
    end

    assign angles.valid = ov_reg;
    assign angles.hip_angle = o_hip_reg;
    assign angles.shoulder_angle = o_sh_reg;
    assign angles.knee_angle = o_kn_reg;
    assign angles.unreachable = o_unr_reg;
endmodule

>>> hw/rtl/leg_inverse_kinematics.sv
`timescale 1ns / 1ps

// Three-joint leg solver: each foot target beat (x, y, z in mm) yields one beat of
// hip, shoulder and knee servo angles in whole degrees, clamped to 0..180, with
// unreachable set (and shoulder and knee zero) when the target is out of reach or
// at zero distance. A front stage squares the coordinates and feeds a two-entry
// queue, so up to three targets can be taken while one is solved. A solve ends early
// when the target is unreachable; it uses the shared square-root unit, which yields
// one result bit a cycle, the shared CORDIC unit, one step a cycle, and the shared
// one-bit-a-cycle divider. Lengths and hip offset are written through cfg_we,
// cfg_index, cfg_data; the user must write them only while the block is idle, and
// the block itself does not enforce this.
module leg_inverse_kinematics #(
    parameter int COORD_BITS = 13,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    lik_target_if.sink  target,
    lik_angle_if.source angles,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    localparam int DATA_W = 7 * COORD_BITS - 1;

    lik_pkg::lik_cfg_t cfg_reg;
    logic push_valid, push_ready, pop_valid, pop;
    logic [DATA_W-1:0] push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coxa_length <= lik_pkg::COXA_RESET;
            cfg_reg.femur_length <= lik_pkg::FEMUR_RESET;
            cfg_reg.tibia_length <= lik_pkg::TIBIA_RESET;
            cfg_reg.hip_offset_deg <= lik_pkg::HIP_OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lik_pkg::CFG_COXA: cfg_reg.coxa_length <= cfg_data;
                lik_pkg::CFG_FEMUR: cfg_reg.femur_length <= cfg_data;
                lik_pkg::CFG_TIBIA: cfg_reg.tibia_length <= cfg_data;
                lik_pkg::CFG_HIP_OFFSET: cfg_reg.hip_offset_deg <= cfg_data[8:0];
            endcase
        end
    end

    lik_front #(
        .COORD_BITS(COORD_BITS),
        .DATA_W(DATA_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .target(target),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(push_data)
    );

    lik_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data(push_data),
        .pop_valid(pop_valid),
        .pop(pop),
        .pop_data(pop_data)
    );

    lik_back #(
        .COORD_BITS(COORD_BITS),
        .CORDIC_STEPS(CORDIC_STEPS),
        .DATA_W(DATA_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .q_valid(pop_valid),
        .q_pop(pop),
        .q_data(pop_data),
        .angles(angles)
    );
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic signed [12:0] z;
    } foot_t;

    typedef struct {
        logic [7:0] hip;
        logic [7:0] shoulder;
        logic [7:0] knee;
        logic       unreachable;
    } joint_t;

    typedef struct {
        logic [11:0]       coxa;
        logic [11:0]       femur;
        logic [11:0]       tibia;
        logic signed [8:0] hip_ofs;
    } leg_cfg_t;

    localparam int STEPS = 16;
    localparam int STALL_LIMIT = 6000;
    localparam int HOLD_CYCLES = 800;

    localparam longint ATAN_DEG_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [11:0] cfg_data;

    lik_target_if #(.COORD_BITS(13)) target ();
    lik_angle_if angles ();

    leg_inverse_kinematics #(.COORD_BITS(13), .CORDIC_STEPS(STEPS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .target(target.sink),
        .angles(angles.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    leg_cfg_t leg;
    foot_t pending_feet[$];
    joint_t expected_joints[$];
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int hold_cnt;
    bit beat_in;
    int errors;
    int solved;
    int unreach_seen;
    int quiet_cycles;

    function automatic longint unsigned isqrt_u64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint cordic_deg(input longint yv, input longint xv);
        longint acc;
        longint t;
        longint dx;
        longint dy;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                t = yv;
                yv = -xv;
                xv = t;
                acc = 90 * 65536;
            end
            else
            begin
                t = -yv;
                yv = xv;
                xv = t;
                acc = -90 * 65536;
            end
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv = xv + dx;
                yv = yv - dy;
                acc = acc + ATAN_DEG_Q16[i];
            end
            else
            begin
                xv = xv - dx;
                yv = yv + dy;
                acc = acc - ATAN_DEG_Q16[i];
            end
        end
        return acc;
    endfunction

    function automatic bit acos_deg(input longint num, input longint unsigned den,
                                    output longint ang);
        longint unsigned mag;
        longint c;
        longint unsigned s;
        ang = 0;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        if (den == 0 || mag > den)
            return 0;
        c = longint'((mag << 16) / den);
        if (num < 0)
            c = -c;
        s = isqrt_u64((64'd1 << 32) - longint'(c * c));
        ang = cordic_deg(longint'(s) * 4096, c * 4096);
        return 1;
    endfunction

    function automatic logic [7:0] servo_deg(input longint q);
        longint t;
        t = q / 65536;
        if (t < 0)
            return 8'd0;
        if (t > 180)
            return 8'd180;
        return t[7:0];
    endfunction

    function automatic joint_t solve_leg(input foot_t ft, input leg_cfg_t c);
        longint x;
        longint y;
        longint z;
        longint f;
        longint t;
        longint hip;
        longint d;
        longint a1;
        longint a2;
        longint kn;
        longint num;
        longint unsigned l1;
        longint unsigned dm;
        longint unsigned lsq;
        longint unsigned lq;
        longint unsigned lsq16;
        bit ok;
        joint_t r;
        x = ft.x;
        y = ft.y;
        z = ft.z;
        f = longint'(c.femur);
        t = longint'(c.tibia);
        hip = cordic_deg(x * 65536, y * 65536) + longint'(c.hip_ofs) * 65536;
        l1 = isqrt_u64(longint'(x * x + y * y) << 32);
        d = longint'(l1) - longint'(c.coxa) * 65536;
        dm = (d < 0) ? longint'(-d) : longint'(d);
        lsq = (longint'(z * z) << 32) + dm * dm;
        lq = isqrt_u64(lsq);
        lsq16 = lsq >> 16;
        ok = (lsq != 0);
        a1 = 0;
        a2 = 0;
        kn = 0;
        if (ok)
        begin
            a1 = cordic_deg(longint'(dm), z * 65536);
            num = longint'(lsq16) + (f * f - t * t) * 65536;
            ok = acos_deg(num, 64'd2 * longint'(f) * lq, a2);
        end
        if (ok)
        begin
            num = (t * t + f * f) * 65536 - longint'(lsq16);
            ok = acos_deg(num, longint'(2 * t * f) << 16, kn);
        end
        r.hip = servo_deg(hip);
        r.shoulder = ok ? servo_deg(a1 + a2) : 8'd0;
        r.knee = ok ? servo_deg(kn) : 8'd0;
        r.unreachable = !ok;
        return r;
    endfunction

    function automatic logic signed [12:0] pick_coord(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        if (v > 4095)
            v = 4095;
        if (v < -4096)
            v = -4096;
        return 13'(v);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            target.valid = 1'b0;
        else if (!target.valid || beat_in)
        begin
            if (pending_feet.size() > 0 && int'($urandom_range(0, 99)) >= send_idle_pct)
            begin
                foot_t ft;
                ft = pending_feet.pop_front();
                target.valid = 1'b1;
                target.target_x = ft.x;
                target.target_y = ft.y;
                target.target_z = ft.z;
            end
            else
                target.valid = 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            angles.ready = 1'b0;
        end
        else
            angles.ready = (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        beat_in = 1'b0;
        if (rst_n)
        begin
            if (target.valid && target.ready)
            begin
                foot_t ft;
                ft.x = target.target_x;
                ft.y = target.target_y;
                ft.z = target.target_z;
                expected_joints.push_back(solve_leg(ft, leg));
                beat_in = 1'b1;
            end
            if (angles.valid && angles.ready)
            begin
                joint_t e;
                solved++;
                if (expected_joints.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat hip=%0d shoulder=%0d knee=%0d unr=%0d",
                             $time, angles.hip_angle, angles.shoulder_angle,
                             angles.knee_angle, angles.unreachable);
                end
                else
                begin
                    e = expected_joints.pop_front();
                    if (e.unreachable)
                        unreach_seen++;
                    if (angles.hip_angle !== e.hip)
                    begin
                        errors++;
                        $display("%0t: hip_angle expected %0d got %0d",
                                 $time, e.hip, angles.hip_angle);
                    end
                    if (angles.shoulder_angle !== e.shoulder)
                    begin
                        errors++;
                        $display("%0t: shoulder_angle expected %0d got %0d",
                                 $time, e.shoulder, angles.shoulder_angle);
                    end
                    if (angles.knee_angle !== e.knee)
                    begin
                        errors++;
                        $display("%0t: knee_angle expected %0d got %0d",
                                 $time, e.knee, angles.knee_angle);
                    end
                    if (angles.unreachable !== e.unreachable)
                    begin
                        errors++;
                        $display("%0t: unreachable expected %0d got %0d",
                                 $time, e.unreachable, angles.unreachable);
                    end
                end
            end
            if ((target.valid && target.ready) || (angles.valid && angles.ready)
                || (pending_feet.size() == 0 && !target.valid && expected_joints.size() == 0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_cfg(input leg_cfg_t c);
        write_reg(lik_pkg::CFG_COXA, c.coxa);
        write_reg(lik_pkg::CFG_FEMUR, c.femur);
        write_reg(lik_pkg::CFG_TIBIA, c.tibia);
        write_reg(lik_pkg::CFG_HIP_OFFSET, 12'(c.hip_ofs));
        leg = c;
    endtask

    task automatic add_foot(input int x, input int y, input int z);
        foot_t ft;
        ft.x = 13'(x);
        ft.y = 13'(y);
        ft.z = 13'(z);
        pending_feet.push_back(ft);
    endtask

    task automatic drain();
        while (pending_feet.size() > 0 || target.valid || expected_joints.size() > 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    initial
    begin
        leg_cfg_t plan[8];
        int reach;
        int mode;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lik_pkg::CFG_COXA;
        cfg_data = '0;
        target.valid = 1'b0;
        target.target_x = '0;
        target.target_y = '0;
        target.target_z = '0;
        angles.ready = 1'b0;
        hold_req = 1'b0;
        hold_cnt = 0;
        beat_in = 1'b0;
        errors = 0;
        solved = 0;
        unreach_seen = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        leg = '{coxa: 12'd30, femur: 12'd60, tibia: 12'd90, hip_ofs: 9'sd45};

        plan[0] = leg;
        plan[1] = '{coxa: 12'd0, femur: 12'd100, tibia: 12'd100, hip_ofs: 9'sd0};
        plan[2] = '{coxa: 12'd4095, femur: 12'd4095, tibia: 12'd4095, hip_ofs: 9'sd180};
        plan[3] = '{coxa: 12'd0, femur: 12'd1, tibia: 12'd1, hip_ofs: -9'sd180};
        plan[4] = '{coxa: 12'd50, femur: 12'd0, tibia: 12'd80, hip_ofs: -9'sd256};
        plan[5] = '{coxa: 12'd20, femur: 12'd70, tibia: 12'd0, hip_ofs: 9'sd255};
        plan[6] = '{coxa: 12'd10, femur: 12'd2000, tibia: 12'd1500, hip_ofs: 9'sd90};
        plan[7] = '{coxa: 12'd40, femur: 12'd120, tibia: 12'd150, hip_ofs: -9'sd45};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_foot(0, 30, 0);
        add_foot(30, 0, 0);
        add_foot(0, 0, 0);
        add_foot(0, 0, 100);
        add_foot(-4096, -4096, -4096);
        add_foot(4095, 4095, 4095);
        add_foot(4095, -4096, 0);
        add_foot(-4096, 4095, 4095);
        add_foot(-50, -50, -40);
        add_foot(50, -50, -40);
        add_foot(-50, 50, 40);
        add_foot(0, 100, -60);
        add_foot(60, 60, -50);
        add_foot(0, 500, 0);
        add_foot(0, 180, 0);
        add_foot(0, 90, 0);
        add_foot(-1, 0, 0);
        add_foot(0, -1, -1);
        add_foot(1, 1, 1);
        add_foot(0, 0, -4096);
        add_foot(-4096, 0, 0);
        add_foot(0, 4095, 0);
        add_foot(100, 0, 50);
        add_foot(-70, 0, -30);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            if (p > 0)
                apply_cfg(plan[p]);
            mode = p % 4;
            send_idle_pct = (mode == 1) ? 65 : (mode == 3) ? 38 : 0;
            recv_stall_pct = (mode == 2) ? 65 : (mode == 3) ? 38 : 0;
            reach = int'(leg.coxa) + int'(leg.femur) + int'(leg.tibia) + 20;
            if (reach > 4095)
                reach = 4095;
            for (int k = 0; k < 240; k++)
            begin
                foot_t ft;
                int r;
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    ft.x = pick_coord(reach);
                    ft.y = pick_coord(reach);
                    ft.z = pick_coord(reach);
                end
                else if (r < 90)
                begin
                    ft.x = 13'($urandom);
                    ft.y = 13'($urandom);
                    ft.z = 13'($urandom);
                end
                else
                begin
                    ft.x = pick_coord(2);
                    ft.y = ($urandom_range(0, 1) != 0) ? 13'(leg.coxa) : pick_coord(2);
                    ft.z = pick_coord(1);
                end
                pending_feet.push_back(ft);
            end
            if (p == 1)
                hold_req = 1'b1;
            drain();
        end

        $display("Solved %0d foot targets (%0d unreachable) over 8 leg settings,",
                 solved, unreach_seen);
        $display("with sender gaps, receiver stalls and one long output hold-off.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lik_pkg.sv
hw/rtl/lik_target_if.sv
hw/rtl/lik_angle_if.sv
hw/rtl/lik_front.sv
hw/rtl/lik_queue.sv
hw/rtl/lik_back.sv
hw/rtl/leg_inverse_kinematics.sv
tb/sv/tb_top.sv
